FILE: rtl/ntt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntt_pkg
// Shared constants and types for the NTT butterfly engine.
// ----------------------------------------------------------------------------
package ntt_pkg;

  localparam int unsigned DefLength = 64;
  localparam int unsigned DefLayers = 6;
  localparam logic [15:0] ModulusRst = 16'd7681;
  localparam logic [4:0]  ShiftRst   = 5'd16;

  // Configuration register indexes
  localparam logic [0:0] RegModulus = 1'b0;
  localparam logic [0:0] RegShift   = 1'b1;

  // Input modes
  localparam logic ModeTwiddle = 1'b0;
  localparam logic ModeSample  = 1'b1;

  typedef enum logic [2:0] {
    ST_LOAD,   // accepting load requests
    ST_TWRD,   // read twiddle for a section
    ST_RDA,    // read upper element
    ST_RDB,    // read lower element, products from upper
    ST_MUL,    // quotient estimate and reduced product, latch lower
    ST_WRA,    // write lower result
    ST_WRB,    // write upper result, advance
    ST_OUT     // stream results
  } ntt_state_t;

endpackage

FILE: rtl/ntt_butterfly_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntt_butterfly_engine
// In-place forward NTT with Shoup twiddle multiply and lazy reduction.
// ----------------------------------------------------------------------------
// Load requests are accepted one per cycle in ST_LOAD. A request with tlast
// runs the transform: each butterfly passes through the single-port sample
// memory in steps (read b, read a, multiply, write a, write b), with a twiddle
// read before each section; then, after a registered memory read, LENGTH
// results follow at one per cycle while out_tready is high.
// Synchronous active-low reset restores the registers to 7681 and 16 and the
// control to loading; memories are not cleared.
module ntt_butterfly_engine
  import ntt_pkg::*;
#(
  parameter int unsigned LENGTH = DefLength,
  parameter int unsigned LAYERS = DefLayers
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // index[5:0], value[15:0], precomputed_factor[15:0], pad
  input  logic        in_tuser,   // mode
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // result[15:0], position[5:0], zero pad
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int unsigned AW  = $clog2(LENGTH);
  localparam int unsigned TW  = AW - 1;
  localparam int unsigned HALF = LENGTH / 2;

  logic [15:0] sample_mem [LENGTH];
  logic [15:0] twid_mem   [HALF];
  logic [15:0] fact_mem   [HALF];

  logic [15:0] modulus_r;
  logic [4:0]  shift_r;
  ntt_state_t  state_r, state_nxt;

  logic [AW-1:0] half_r, half_nxt;     // current half span
  logic [AW-1:0] sec_r, sec_nxt;       // section index
  logic [AW-1:0] k_r, k_nxt;           // offset in section
  logic [2:0]    layer_r, layer_nxt;
  logic [AW:0]   opos_r, opos_nxt;     // output position
  logic [15:0]   w_r, f_r, a_r, rd_r, tt_r;
  logic [31:0]   bw_r, bf_r;

  // Input fields
  logic          in_mode;
  logic [5:0]    in_index;
  logic [15:0]   in_value, in_fac;
  assign in_mode  = in_tuser;
  assign in_index = in_tdata[5:0];
  assign in_value = in_tdata[21:6];
  assign in_fac   = in_tdata[37:22];

  logic in_acc;
  assign in_tready = (state_r == ST_LOAD);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;

  // Addresses
  logic [AW:0] lo_w, hi_w;
  assign lo_w = (AW+1)'(({1'b0, sec_r} * {1'b0, half_r}) << 1) + (AW+1)'(k_r);
  assign hi_w = lo_w + (AW+1)'(half_r);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= ModulusRst;
      shift_r   <= ShiftRst;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegModulus: modulus_r <= cfg_data;
        RegShift:   shift_r   <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Twiddle memory
  always_ff @(posedge clk) begin
    if (in_acc && in_mode == ModeTwiddle && {1'b0, in_index} < 7'(HALF)) begin
      twid_mem[in_index[TW-1:0]] <= in_value;
      fact_mem[in_index[TW-1:0]] <= in_fac;
    end
    w_r <= twid_mem[sec_r[TW-1:0]];
    f_r <= fact_mem[sec_r[TW-1:0]];
  end

  // Sample memory, single port
  logic          s_we;
  logic [AW-1:0] s_addr;
  logic [15:0]   s_wd;
  logic [15:0]   ta, tb;
  assign ta = a_r + tt_r;
  assign tb = a_r - tt_r + modulus_r;

  always_comb begin
    s_we = 1'b0; s_addr = '0; s_wd = '0;
    unique case (state_r)
      ST_LOAD: begin
        s_we   = in_acc && in_mode == ModeSample && {1'b0, in_index} < 7'(LENGTH);
        s_addr = in_index[AW-1:0];
        s_wd   = in_value;
      end
      ST_RDA:  s_addr = hi_w[AW-1:0];
      ST_RDB:  s_addr = lo_w[AW-1:0];
      ST_WRA:  begin s_we = 1'b1; s_addr = lo_w[AW-1:0]; s_wd = ta; end
      ST_WRB:  begin s_we = 1'b1; s_addr = hi_w[AW-1:0]; s_wd = tb; end
      ST_OUT:  s_addr = opos_nxt[AW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (s_we) sample_mem[s_addr] <= s_wd;
    rd_r <= sample_mem[s_addr];
  end

  // Datapath registers: upper element arrives in RDB, lower in MUL
  logic [31:0] tq;
  logic [31:0] qt;
  assign tq = bf_r >> shift_r;
  assign qt = {16'd0, modulus_r} * {16'd0, tq[15:0]};
  always_ff @(posedge clk) begin
    if (state_r == ST_RDB) begin
      bw_r <= {16'd0, rd_r} * {16'd0, w_r};
      bf_r <= {16'd0, rd_r} * {16'd0, f_r};
    end
    if (state_r == ST_MUL) begin
      a_r  <= rd_r;
      tt_r <= 16'(bw_r - qt);
    end
  end

  // Next state
  logic last_bfly_sec, last_sec, last_layer;
  assign last_bfly_sec = (k_r == half_r - 1'b1);
  assign last_sec      = ((sec_r + 1'b1) * half_r * 2 >= LENGTH) || (sec_r == AW'(HALF - 1));
  assign last_layer    = (layer_r == 3'(LAYERS - 1)) || (half_r == 1);

  always_comb begin
    state_nxt = state_r; half_nxt = half_r; sec_nxt = sec_r; k_nxt = k_r;
    layer_nxt = layer_r; opos_nxt = opos_r;
    unique case (state_r)
      ST_LOAD: if (in_acc && in_tlast) begin
        state_nxt = ST_TWRD; half_nxt = AW'(HALF); sec_nxt = '0;
        k_nxt = '0; layer_nxt = '0;
      end
      ST_TWRD: state_nxt = ST_RDA;
      ST_RDA:  state_nxt = ST_RDB;
      ST_RDB:  state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_WRA;
      ST_WRA:  state_nxt = ST_WRB;
      ST_WRB: begin
        if (!last_bfly_sec) begin
          k_nxt = k_r + 1'b1; state_nxt = ST_RDA;
        end else if (!last_sec) begin
          k_nxt = '0; sec_nxt = sec_r + 1'b1; state_nxt = ST_TWRD;
        end else if (!last_layer) begin
          k_nxt = '0; sec_nxt = '0; half_nxt = half_r >> 1;
          layer_nxt = layer_r + 1'b1; state_nxt = ST_TWRD;
        end else begin
          opos_nxt = '0; state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_tvalid || out_tready) begin
          if (out_tvalid && opos_r == (AW+1)'(LENGTH - 1)) state_nxt = ST_LOAD;
          else if (out_tvalid) opos_nxt = opos_r + 1'b1;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD; half_r <= '0; sec_r <= '0; k_r <= '0;
      layer_r <= '0; opos_r <= '0;
    end else begin
      state_r <= state_nxt; half_r <= half_nxt; sec_r <= sec_nxt; k_r <= k_nxt;
      layer_r <= layer_nxt; opos_r <= opos_nxt;
    end
  end

  // Output: the read of the next position is issued from opos_nxt and registered,
  // so the memory data matches opos_r from the cycle after entry to ST_OUT on
  logic out_v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else out_v_r <= (state_r == ST_OUT) && (state_nxt == ST_OUT);
  end

  logic [15:0] res;
  assign res = (rd_r >= modulus_r) ? rd_r - modulus_r : rd_r;

  assign out_tvalid = (state_r == ST_OUT) && out_v_r;
  assign out_tdata  = {2'b00, opos_r[5:0] & 6'((1 << AW) - 1), res};
  assign out_tlast  = (opos_r == (AW+1)'(LENGTH - 1));

  logic unused;
  assign unused = ^{in_tdata[39:38], tq[31:16]};

endmodule
